### rtl/core/nagr_pkg.sv
// ----------------------------------------------------------------------------
// nagr_pkg: shared types and constants for the gauge reading block
// Holds widths, the arctangent table and the word passed from front to back.
// ----------------------------------------------------------------------------
package nagr_pkg;

  localparam int unsigned CoordWidth = 12;
  localparam int unsigned AtanIters  = 16;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  // x grows by at most about 1.65x; 24 fraction bits plus headroom.
  localparam int unsigned CordWidth  = DiffWidth + 24 + 2;
  localparam int unsigned ZWidth     = 24;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrWidth  = 2;

  localparam logic signed [15:0] NinetyQ8   = 16'sd23040;
  localparam logic signed [15:0] Minus30Q8  = -16'sd7680;

  // Item as classified by the front part.
  typedef struct packed {
    logic                        valid_angle;
    logic signed [DiffWidth-1:0] dx;
    logic signed [DiffWidth-1:0] dy;
  } front_word_t;

  // Result word.
  typedef struct packed {
    logic [14:0]        reading;
    logic signed [15:0] angle;
    logic               angle_valid;
  } result_t;

  // atan(2^-i) in Q16 degrees.
  function automatic logic signed [ZWidth-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZWidth-1:0] v;
    begin
      unique case (idx)
        5'd0: v = 24'sd2949120;  5'd1: v = 24'sd1740967;
        5'd2: v = 24'sd919879;   5'd3: v = 24'sd466945;
        5'd4: v = 24'sd234379;   5'd5: v = 24'sd117304;
        5'd6: v = 24'sd58666;    5'd7: v = 24'sd29335;
        5'd8: v = 24'sd14668;    5'd9: v = 24'sd7334;
        5'd10: v = 24'sd3667;    5'd11: v = 24'sd1833;
        5'd12: v = 24'sd917;     5'd13: v = 24'sd458;
        5'd14: v = 24'sd229;     5'd15: v = 24'sd115;
        5'd16: v = 24'sd57;      5'd17: v = 24'sd29;
        5'd18: v = 24'sd14;      5'd19: v = 24'sd7;
        5'd20: v = 24'sd4;       5'd21: v = 24'sd2;
        5'd22: v = 24'sd1;       default: v = '0;
      endcase
      atan_entry = v;
    end
  endfunction

endpackage

### rtl/core/needle_angle_to_gauge_reading.sv
// Path from an accepted push to the result ports: the front register, the
// queue write, then 20 back stages (prescale, 16 CORDIC steps, rounding,
// reading multiply, output register), after any older words held in the queue.
// Throughput: one word per cycle unless stalled; the CORDIC is fully pipelined.
// A full output stalls the pipeline; the queue absorbs front words meanwhile.
// Reset clears all valid flags and queue pointers; data registers are not reset.
// ----------------------------------------------------------------------------
// needle_angle_to_gauge_reading: top level
// Converts needle tip and dial center pixels into an angle and gauge reading.
// ----------------------------------------------------------------------------
module needle_angle_to_gauge_reading (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [nagr_pkg::CoordWidth-1:0] tip_x_i,
  input  logic [nagr_pkg::CoordWidth-1:0] tip_y_i,
  input  logic [nagr_pkg::CoordWidth-1:0] center_x_i,
  input  logic [nagr_pkg::CoordWidth-1:0] center_y_i,
  output logic        empty,
  input  logic        pop,
  output logic [14:0] reading_q8_o,
  output logic signed [15:0] angle_q8_o,
  output logic        angle_valid_o
);

  logic                  f_valid, f_ready, q_valid, q_ready, in_ready, b_valid;
  nagr_pkg::front_word_t f_word, q_word;
  nagr_pkg::result_t     b_word;

  assign full  = !in_ready;
  assign empty = !b_valid;

  // Front part: differences and classification.
  nagr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_ready_o(in_ready),
    .tip_x_i, .tip_y_i, .center_x_i, .center_y_i,
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_word_o(f_word)
  );

  // Queue between the two parts.
  nagr_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_word_i(f_word),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_word_o(q_word)
  );

  // Back part: CORDIC and reading.
  nagr_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_word_i(q_word),
    .out_valid_o(b_valid), .out_ready_i(pop), .out_word_o(b_word)
  );

  assign reading_q8_o  = b_word.reading;
  assign angle_q8_o    = b_word.angle;
  assign angle_valid_o = b_word.angle_valid;

`ifndef SYNTHESIS
  // An invalid angle always reports ninety and zero.
  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !angle_valid_o) |-> (reading_q8_o == 15'd23040 && angle_q8_o == 16'sd0))
    else $error("invalid angle word malformed");
  // Reading never exceeds ninety degrees.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (reading_q8_o <= 15'd23040))
    else $error("reading out of range");
  // A held result stays put until popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(reading_q8_o) && $stable(angle_q8_o)))
    else $error("result changed while stalled");
`endif

endmodule

### rtl/core/nagr_front.sv
// ----------------------------------------------------------------------------
// nagr_front: difference and classification stage
// Forms dx and dy and flags whether the needle lies left of the center.
// ----------------------------------------------------------------------------
module nagr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [nagr_pkg::CoordWidth-1:0] tip_x_i,
  input  logic [nagr_pkg::CoordWidth-1:0] tip_y_i,
  input  logic [nagr_pkg::CoordWidth-1:0] center_x_i,
  input  logic [nagr_pkg::CoordWidth-1:0] center_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output nagr_pkg::front_word_t        out_word_o
);

  logic                  valid_q;
  nagr_pkg::front_word_t word_q, word_d;

  // The stage advances whenever its slot is free or being drained.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    word_d.dx = $signed({1'b0, center_x_i}) - $signed({1'b0, tip_x_i});
    word_d.dy = $signed({1'b0, center_y_i}) - $signed({1'b0, tip_y_i});
    word_d.valid_angle = (word_d.dx > 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

### rtl/core/nagr_fifo.sv
// ----------------------------------------------------------------------------
// nagr_fifo: short queue between front and back parts
// Register-based queue of front words with valid/ready on both sides.
// ----------------------------------------------------------------------------
module nagr_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  nagr_pkg::front_word_t wr_word_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output nagr_pkg::front_word_t rd_word_o
);

  nagr_pkg::front_word_t mem_q [nagr_pkg::QDepth];
  logic [nagr_pkg::QPtrWidth-1:0] wptr_q, rptr_q;
  logic [nagr_pkg::QPtrWidth:0]   cnt_q;
  logic wr_en, rd_en;

  assign wr_ready_o = (cnt_q != (nagr_pkg::QPtrWidth+1)'(nagr_pkg::QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;
  assign rd_word_o = mem_q[rptr_q];

  // Pointer and fill-count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) wptr_q <= wptr_q + 1'b1;
      if (rd_en) rptr_q <= rptr_q + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wr_word_i;
    end
  end

endmodule

### rtl/core/nagr_back.sv
// ----------------------------------------------------------------------------
// nagr_back: CORDIC pipeline and reading conversion
// One CORDIC step per stage, then rounding, saturation and the reading map.
// ----------------------------------------------------------------------------
module nagr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nagr_pkg::front_word_t in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output nagr_pkg::result_t     out_word_o
);

  localparam int unsigned N  = nagr_pkg::AtanIters;
  localparam int unsigned CW = nagr_pkg::CordWidth;
  localparam int unsigned ZW = nagr_pkg::ZWidth;
  // stages: prescale, N cordic, round/saturate, reading multiply, output register
  localparam int unsigned NS = N + 4;

  logic                 adv;
  logic [NS-1:0]        v_q;
  logic                 ok_q [N+1];
  logic signed [CW-1:0] x_q  [N+1];
  logic signed [CW-1:0] y_q  [N+1];
  logic signed [ZW-1:0] z_q  [N+1];
  logic                 ok2_q;
  logic signed [15:0]   a_q, a_d;
  logic                 ok3_q;
  logic signed [15:0]   a3_q;
  logic [17:0]          rd_q;
  nagr_pkg::result_t    res_q, res_d;

  // Whole pipeline stalls together when the final result is held.
  assign adv        = !v_q[NS-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Stage zero: prescale the differences by 2^24.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q[0] <= in_word_i.valid_angle;
      x_q[0]  <= {CW'(in_word_i.dx)} <<< 24;
      y_q[0]  <= {CW'(in_word_i.dy)} <<< 24;
      z_q[0]  <= '0;
    end
  end

  // One vectoring CORDIC step per stage.
  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ok_q[i+1] <= ok_q[i];
        if (!y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + nagr_pkg::atan_entry(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - nagr_pkg::atan_entry(5'(i));
        end
      end
    end
  end

  // Round to Q8 and saturate to plus or minus ninety degrees.
  always_comb begin
    logic signed [ZW-1:0] zr;
    logic signed [ZW-9:0] zs;
    zr = z_q[N] + ZW'(128);
    zs = zr[ZW-1:8];
    if (zs > (ZW-8)'(nagr_pkg::NinetyQ8)) begin
      a_d = nagr_pkg::NinetyQ8;
    end else if (zs < -(ZW-8)'(nagr_pkg::NinetyQ8)) begin
      a_d = -nagr_pkg::NinetyQ8;
    end else begin
      a_d = zs[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok2_q <= ok_q[N];
      a_q   <= a_d;
    end
  end

  // Numerator 2a + 23041 lies in 7681..69121 when in range; divide by 3
  // with a reciprocal multiply: floor(n * 43691 / 2^17) is exact here.
  always_ff @(posedge clk_i) begin
    logic [16:0] num;
    num = 17'(18'($signed({a_q, 1'b0})) + 18'(23041));
    if (adv) begin
      ok3_q <= ok2_q;
      a3_q  <= a_q;
      rd_q  <= 18'((34'(num) * 34'd43691) >> 17);
    end
  end

  always_comb begin
    res_d.angle_valid = ok3_q;
    if (!ok3_q) begin
      res_d.reading = 15'(nagr_pkg::NinetyQ8);
      res_d.angle   = '0;
    end else if (a3_q < nagr_pkg::Minus30Q8) begin
      res_d.reading = '0;
      res_d.angle   = a3_q;
    end else begin
      res_d.reading = rd_q[14:0];
      res_d.angle   = a3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_word_o  = res_q;

endmodule
